/* rtl/sble_pkg.sv */
// ----------------------------------------------------------------------------
// sble_pkg
// Shared constants, action and status codes, and the control/status structs
// passed between the controller and the datapath of the sorted byte list.
// ----------------------------------------------------------------------------
`default_nettype none

package sble_pkg;

   // List depth and derived widths
   localparam int Capacity = 16;
   localparam int IdxW     = $clog2(Capacity);
   localparam int CntW     = $clog2(Capacity + 1);

   // Action codes
   localparam logic [2:0] ActPushFront = 3'd0;
   localparam logic [2:0] ActPushBack  = 3'd1;
   localparam logic [2:0] ActSorted    = 3'd2;
   localparam logic [2:0] ActDelete    = 3'd3;
   localparam logic [2:0] ActPop       = 3'd4;
   localparam logic [2:0] ActDump      = 3'd5;

   // Status codes
   localparam logic [1:0] StsOk      = 2'd0;
   localparam logic [1:0] StsEmpty   = 2'd1;
   localparam logic [1:0] StsFull    = 2'd2;
   localparam logic [1:0] StsMissing = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic            apply;      // execute the accepted action, load response
      logic            step;       // load the next dump entry into the response
      logic [IdxW-1:0] idx;        // dump entry to list on a step
      logic            step_last;  // this step lists the final entry
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [CntW-1:0] used;
   } stat_type;

endpackage

`default_nettype wire

/* rtl/sble_if.sv */
// ----------------------------------------------------------------------------
// sble_if
// Valid/ready channel interfaces for the request and response transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface sble_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

interface sble_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] entry;
   logic [1:0] status;
   logic [4:0] size;
   logic       last;

   modport source (output valid, output entry, output status, output size,
                   output last, input ready);
   modport sink   (input valid, input entry, input status, input size,
                   input last, output ready);
endinterface

`default_nettype wire

/* rtl/sble_datapath.sv */
// ----------------------------------------------------------------------------
// sble_datapath
// Row of slot registers with compare-and-shift cells, entry counter and the
// response payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module sble_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sble_pkg::cmd_type cmd,
   input  wire logic [2:0]        action,
   input  wire logic [7:0]        value,
   output sble_pkg::stat_type     stat,
   output logic [7:0]             entry,
   output logic [1:0]             status,
   output logic [4:0]             size,
   output logic                   last
);

   logic [7:0]                    slots_ff [sble_pkg::Capacity];
   logic [7:0]                    slots_in [sble_pkg::Capacity];
   logic                          slots_we;
   logic [sble_pkg::CntW-1:0]     used_ff;
   logic [sble_pkg::CntW-1:0]     used_in;
   logic [7:0]                    entry_ff, entry_in;
   logic [1:0]                    status_ff, status_in;
   logic [4:0]                    size_ff, size_in;
   logic                          last_ff, last_in;

   logic [sble_pkg::Capacity-1:0] inuse, greater, equal;
   logic [sble_pkg::Capacity-1:0] stay, hit_pre;
   logic [7:0]                    ins_row [sble_pkg::Capacity];
   logic [7:0]                    del_row [sble_pkg::Capacity];
   logic [7:0]                    pop_row [sble_pkg::Capacity];
   logic                          full, empty, found;
   logic [sble_pkg::CntW+4:0]     size_wide;

   assign full  = (used_ff == sble_pkg::CntW'(sble_pkg::Capacity));
   assign empty = (used_ff == '0);

   // Per-cell compares against the request value
   always_comb begin
      for (int i = 0; i < sble_pkg::Capacity; i++) begin
         inuse[i]   = (sble_pkg::CntW'(i) < used_ff);
         greater[i] = inuse[i] && (value > slots_ff[i]);
         equal[i]   = inuse[i] && (value == slots_ff[i]);
      end
   end

   // Cells that keep their entry on an insert (always a leading run)
   always_comb begin
      stay = '0;
      case (action)
         sble_pkg::ActPushBack: begin
            stay = inuse;
         end
         sble_pkg::ActSorted: begin
            stay[0] = greater[0];
            for (int i = 1; i < sble_pkg::Capacity; i++) begin
               stay[i] = stay[i-1] && greater[i];
            end
         end
         default: begin
            stay = '0;
         end
      endcase
   end

   // First-match prefix for delete
   always_comb begin
      hit_pre[0] = equal[0];
      for (int i = 1; i < sble_pkg::Capacity; i++) begin
         hit_pre[i] = hit_pre[i-1] || equal[i];
      end
   end
   assign found = hit_pre[sble_pkg::Capacity-1];

   // Shifted rows: insert opens a gap, delete and pop close one
   always_comb begin
      ins_row[0] = stay[0] ? slots_ff[0] : value;
      for (int i = 1; i < sble_pkg::Capacity; i++) begin
         if (stay[i]) begin
            ins_row[i] = slots_ff[i];
         end else if (stay[i-1]) begin
            ins_row[i] = value;
         end else begin
            ins_row[i] = slots_ff[i-1];
         end
      end
      for (int i = 0; i < sble_pkg::Capacity - 1; i++) begin
         del_row[i] = hit_pre[i] ? slots_ff[i+1] : slots_ff[i];
         pop_row[i] = slots_ff[i+1];
      end
      del_row[sble_pkg::Capacity-1] = slots_ff[sble_pkg::Capacity-1];
      pop_row[sble_pkg::Capacity-1] = slots_ff[sble_pkg::Capacity-1];
   end

   // Action decode
   always_comb begin
      slots_we  = 1'b0;
      slots_in  = ins_row;
      used_in   = used_ff;
      entry_in  = entry_ff;
      status_in = status_ff;
      last_in   = last_ff;
      if (cmd.apply) begin
         entry_in  = 8'd0;
         status_in = sble_pkg::StsOk;
         last_in   = 1'b1;
         case (action)
            sble_pkg::ActPushFront, sble_pkg::ActPushBack, sble_pkg::ActSorted: begin
               if (full) begin
                  status_in = sble_pkg::StsFull;
               end else begin
                  slots_we = 1'b1;
                  used_in  = used_ff + 1'b1;
               end
            end
            sble_pkg::ActDelete: begin
               slots_in = del_row;
               if (empty) begin
                  status_in = sble_pkg::StsEmpty;
               end else if (!found) begin
                  status_in = sble_pkg::StsMissing;
               end else begin
                  slots_we = 1'b1;
                  used_in  = used_ff - 1'b1;
               end
            end
            sble_pkg::ActPop: begin
               slots_in = pop_row;
               if (empty) begin
                  status_in = sble_pkg::StsEmpty;
               end else begin
                  entry_in = slots_ff[0];
                  slots_we = 1'b1;
                  used_in  = used_ff - 1'b1;
               end
            end
            sble_pkg::ActDump: begin
               if (empty) begin
                  status_in = sble_pkg::StsEmpty;
               end else begin
                  entry_in = slots_ff[0];
                  last_in  = (used_ff == sble_pkg::CntW'(1));
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.step) begin
         entry_in  = slots_ff[cmd.idx];
         status_in = sble_pkg::StsOk;
         last_in   = cmd.step_last;
      end
   end

   // Size reported is the count after the action, kept to five bits
   assign size_wide = {5'd0, used_in};
   assign size_in   = (cmd.apply || cmd.step) ? size_wide[4:0] : size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slots_we) begin
         slots_ff <= slots_in;
      end
      entry_ff  <= entry_in;
      status_ff <= status_in;
      size_ff   <= size_in;
      last_ff   <= last_in;
   end

   assign stat.used = used_ff;
   assign entry     = entry_ff;
   assign status    = status_ff;
   assign size      = size_ff;
   assign last      = last_ff;

endmodule

`default_nettype wire

/* rtl/sble_ctrl.sv */
// ----------------------------------------------------------------------------
// sble_ctrl
// Controller: request acceptance, response valid and the dump sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module sble_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         action,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire sble_pkg::stat_type stat,
   output sble_pkg::cmd_type       cmd
);

   localparam logic StIdle = 1'b0;
   localparam logic StDump = 1'b1;

   logic                  state_ff, state_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [sble_pkg::IdxW-1:0] idx_ff, idx_in;
   logic                  out_free;
   logic                  at_last;

   // Response register can take a new transaction
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign at_last  = ((sble_pkg::CntW'(idx_ff) + 1'b1) == stat.used);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      req_ready     = 1'b0;
      cmd.apply     = 1'b0;
      cmd.step      = 1'b0;
      cmd.idx       = idx_ff;
      cmd.step_last = at_last;
      case (state_ff)
         StIdle: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               cmd.apply    = 1'b1;
               rsp_valid_in = 1'b1;
               // Dump of more than one entry: list the rest one per cycle while the response register is free
               if (action == sble_pkg::ActDump &&
                   stat.used > sble_pkg::CntW'(1)) begin
                  state_in = StDump;
                  idx_in   = sble_pkg::IdxW'(1);
               end
            end
         end
         StDump: begin
            if (out_free) begin
               cmd.step     = 1'b1;
               rsp_valid_in = 1'b1;
               idx_in       = idx_ff + 1'b1;
               if (at_last) begin
                  state_in = StIdle;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* rtl/sorted_byte_list_engine_core.sv */
// ----------------------------------------------------------------------------
// sorted_byte_list_engine_core
// Bounded ordered list of bytes: push front/back, sorted insert, delete by
// value, pop front and dump, one response per action or per listed entry.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------------------
//   req_ch   | in  | valid / ready | action[2:0], value[7:0]
//   rsp_ch   | out | valid / ready | entry[7:0], status[1:0], size[4:0], last
//
// Every action other than a dump completes in the cycle it is accepted: the
// compare-and-shift row updates all slots at once; the response is registered.
// A dump of N entries gives N responses, one per cycle unless rsp_ch stalls,
// from a sequencer reading the slot row; req_ch is held off until its last
// entry is loaded. Synchronous active-high reset empties the list; no
// clearing pass. Otherwise requests are taken when the response register is
// empty or being read, so back-pressure on rsp_ch stalls req_ch directly.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_byte_list_engine_core (
   input  wire logic  clock,
   input  wire logic  reset,
   sble_req_if.sink   req_ch,
   sble_rsp_if.source rsp_ch
);

   sble_pkg::cmd_type  cmd;
   sble_pkg::stat_type stat;

   sble_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .action    (req_ch.action),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sble_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .action (req_ch.action),
      .value  (req_ch.value),
      .stat   (stat),
      .entry  (rsp_ch.entry),
      .status (rsp_ch.status),
      .size   (rsp_ch.size),
      .last   (rsp_ch.last)
   );

endmodule

`default_nettype wire

/* sim/sorted_byte_list_engine_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_byte_list_engine_core_tb
// Self-checking bench for the sorted byte list. Requests are driven over the
// req channel with random gaps. A local copy of the list works out every
// response, and each response taken from the rsp channel is compared field
// by field with the oldest outstanding expectation. Directed tests cover the
// empty and full lists, duplicate and extreme values and unknown actions.
// Random tests then swing the list between empty and full.
// ----------------------------------------------------------------------------

module sorted_byte_list_engine_core_tb;

   // Action codes the block ignores
   localparam logic [2:0] ActSpareA = 3'd6;
   localparam logic [2:0] ActSpareB = 3'd7;

   // Cycles with no transaction on either channel before giving up
   localparam int StallLimit = 2000;
   // Settling time after the last response
   localparam int TailCycles = sble_pkg::Capacity + 4;

   typedef struct packed {
      logic [7:0] entry;
      logic [1:0] status;
      logic [4:0] size;
      logic       last;
   } list_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sble_req_if req_if ();
   sble_rsp_if rsp_if ();

   sorted_byte_list_engine_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // Local copy of the list, front first, and responses still owed
   logic [7:0]   list_model[$];
   list_rsp_type due_rsp[$];

   int mismatch_count = 0;
   int quiet_cycles   = 0;
   bit req_idle_en    = 1'b1;
   bit rsp_stall_en   = 1'b1;

   always #4 clock = ~clock;

   // Record one response the block owes, with the list size as it now stands
   task automatic owe_rsp(input logic [7:0] entry, input logic [1:0] status,
                          input logic last);
      list_rsp_type rsp;
      rsp.entry  = entry;
      rsp.status = status;
      rsp.size   = 5'(list_model.size());
      rsp.last   = last;
      due_rsp.push_back(rsp);
   endtask

   // Apply one accepted action to the local list and queue its responses
   task automatic apply_list_action(input logic [2:0] act, input logic [7:0] val);
      int pos;
      int cnt;
      logic [7:0] front;
      cnt = list_model.size();
      case (act)
         sble_pkg::ActPushFront, sble_pkg::ActPushBack, sble_pkg::ActSorted: begin
            if (cnt >= sble_pkg::Capacity) begin
               owe_rsp(8'h00, sble_pkg::StsFull, 1'b1);
            end else begin
               if (act == sble_pkg::ActPushFront) begin
                  list_model.push_front(val);
               end else if (act == sble_pkg::ActPushBack) begin
                  list_model.push_back(val);
               end else begin
                  // before the first entry not smaller, unsigned compare
                  pos = 0;
                  while (pos < cnt && val > list_model[pos])
                     pos++;
                  list_model.insert(pos, val);
               end
               owe_rsp(8'h00, sble_pkg::StsOk, 1'b1);
            end
         end
         sble_pkg::ActDelete: begin
            if (cnt == 0) begin
               owe_rsp(8'h00, sble_pkg::StsEmpty, 1'b1);
            end else begin
               pos = 0;
               while (pos < cnt && list_model[pos] != val)
                  pos++;
               if (pos < cnt) begin
                  list_model.delete(pos);
                  owe_rsp(8'h00, sble_pkg::StsOk, 1'b1);
               end else begin
                  owe_rsp(8'h00, sble_pkg::StsMissing, 1'b1);
               end
            end
         end
         sble_pkg::ActPop: begin
            if (cnt == 0) begin
               owe_rsp(8'h00, sble_pkg::StsEmpty, 1'b1);
            end else begin
               front = list_model.pop_front();
               owe_rsp(front, sble_pkg::StsOk, 1'b1);
            end
         end
         sble_pkg::ActDump: begin
            if (cnt == 0) begin
               owe_rsp(8'h00, sble_pkg::StsEmpty, 1'b1);
            end else begin
               for (pos = 0; pos < cnt; pos++)
                  owe_rsp(list_model[pos], sble_pkg::StsOk, pos == cnt - 1);
            end
         end
         default: begin
            owe_rsp(8'h00, sble_pkg::StsOk, 1'b1);
         end
      endcase
   endtask

   // Send one request transaction; called and returns at a falling edge
   task automatic send_item(input logic [2:0] act, input logic [7:0] val);
      while (req_idle_en && $urandom_range(99) < 33) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid  = 1'b1;
      req_if.action = act;
      req_if.value  = val;
      do
         @(posedge clock);
      while (!req_if.ready);
      apply_list_action(act, val);
      @(negedge clock);
   endtask

   // Hold off new requests until every owed response has come back
   task automatic wait_for_drain();
      req_if.valid = 1'b0;
      while (due_rsp.size() != 0)
         @(negedge clock);
   endtask

   // Biased byte: extremes and a narrow band for duplicates
   function automatic logic [7:0] pick_byte();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) return 8'h00;
      if (roll < 20) return 8'hFF;
      if (roll < 45) return 8'h40 + 8'($urandom_range(7));
      return 8'($urandom_range(255));
   endfunction

   // Pop, delete and dump on an empty list
   task automatic test_empty_list();
      send_item(sble_pkg::ActPop, 8'h00);
      send_item(sble_pkg::ActDelete, 8'hA5);
      send_item(sble_pkg::ActDump, 8'h5A);
   endtask

   // Unknown actions leave the list alone
   task automatic test_unknown_action();
      send_item(ActSpareA, 8'hFF);
      send_item(ActSpareB, 8'h00);
   endtask

   // Fill to capacity with all three insert kinds, extremes and duplicates,
   // then try each insert kind on the full list and dump it
   task automatic test_fill_to_full();
      send_item(sble_pkg::ActSorted, 8'h80);
      send_item(sble_pkg::ActSorted, 8'h80);
      send_item(sble_pkg::ActSorted, 8'h7F);
      send_item(sble_pkg::ActSorted, 8'h00);
      send_item(sble_pkg::ActSorted, 8'hFF);
      send_item(sble_pkg::ActPushFront, 8'hFF);
      send_item(sble_pkg::ActPushBack, 8'h00);
      send_item(sble_pkg::ActPushFront, 8'h01);
      send_item(sble_pkg::ActPushBack, 8'hFE);
      send_item(sble_pkg::ActSorted, 8'h40);
      send_item(sble_pkg::ActSorted, 8'hC0);
      send_item(sble_pkg::ActPushFront, 8'h55);
      send_item(sble_pkg::ActPushBack, 8'hAA);
      send_item(sble_pkg::ActSorted, 8'h80);
      send_item(sble_pkg::ActSorted, 8'h10);
      send_item(sble_pkg::ActSorted, 8'hF0);
      send_item(sble_pkg::ActPushFront, 8'h11);
      send_item(sble_pkg::ActPushBack, 8'h22);
      send_item(sble_pkg::ActSorted, 8'h33);
      send_item(sble_pkg::ActDump, 8'h00);
   endtask

   // Pop the front, delete an absent value and the first of a duplicate
   task automatic test_pop_and_delete();
      send_item(sble_pkg::ActPop, 8'h00);
      send_item(sble_pkg::ActDelete, 8'h99);
      send_item(sble_pkg::ActDelete, 8'h80);
   endtask

   // Random traffic in blocks of 40 that alternately grow and shrink the list
   task automatic test_random_mix(input int count);
      int done;
      int roll;
      bit grow;
      logic [2:0] act;
      logic [7:0] val;
      done = 0;
      while (done < count) begin
         grow = ((done / 40) % 2) == 0;
         roll = $urandom_range(99);
         val  = pick_byte();
         if (roll < 3) begin
            act = $urandom_range(1) ? ActSpareB : ActSpareA;
         end else if (roll < (grow ? 68 : 23)) begin
            case ($urandom_range(2))
               0:       act = sble_pkg::ActPushFront;
               1:       act = sble_pkg::ActPushBack;
               default: act = sble_pkg::ActSorted;
            endcase
         end else if (roll < (grow ? 80 : 58)) begin
            act = sble_pkg::ActDelete;
            // mostly hit a value that is present
            if (list_model.size() != 0 && $urandom_range(9) < 6)
               val = list_model[$urandom_range(list_model.size() - 1)];
         end else if (roll < (grow ? 90 : 88)) begin
            act = sble_pkg::ActPop;
         end else begin
            act = sble_pkg::ActDump;
         end
         send_item(act, val);
         if (act != ActSpareA && act != ActSpareB)
            done++;
      end
   endtask

   // Response side back-pressure
   always @(negedge clock) begin
      rsp_if.ready <= !(rsp_stall_en && $urandom_range(99) < 33);
   end

   // Compare each response transaction with the oldest one owed
   always @(posedge clock) begin : rsp_check
      list_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (due_rsp.size() == 0) begin
            if (mismatch_count < 10)
               $display("%0t: unexpected response entry=%h status=%0d size=%0d last=%b",
                        $realtime, rsp_if.entry, rsp_if.status, rsp_if.size,
                        rsp_if.last);
            mismatch_count++;
         end else begin
            want = due_rsp.pop_front();
            if (rsp_if.entry !== want.entry || rsp_if.status !== want.status ||
                rsp_if.size !== want.size || rsp_if.last !== want.last) begin
               if (mismatch_count < 10)
                  $display("%0t: response mismatch: expected entry=%h status=%0d ",
                           $realtime, want.entry, want.status,
                           "size=%0d last=%b, got entry=%h status=%0d ",
                           want.size, want.last, rsp_if.entry, rsp_if.status,
                           "size=%0d last=%b", rsp_if.size, rsp_if.last);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: no transaction on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Test sequence
   initial begin
      req_if.valid  = 1'b0;
      req_if.action = sble_pkg::ActPushFront;
      req_if.value  = 8'h00;
      rsp_if.ready  = 1'b0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      test_empty_list();
      test_unknown_action();
      test_fill_to_full();
      test_pop_and_delete();
      wait_for_drain();

      test_random_mix(160);

      // stretch with no idling on either side
      req_idle_en  = 1'b0;
      rsp_stall_en = 1'b0;
      test_random_mix(50);
      wait_for_drain();
      req_idle_en  = 1'b1;
      rsp_stall_en = 1'b1;

      test_random_mix(80);

      wait_for_drain();
      repeat (TailCycles) @(negedge clock);

      if (mismatch_count == 0 && due_rsp.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

/* sorted_byte_list_engine_core.f */
rtl/sble_pkg.sv
rtl/sble_if.sv
rtl/sble_datapath.sv
rtl/sble_ctrl.sv
rtl/sorted_byte_list_engine_core.sv
sim/sorted_byte_list_engine_core_tb.sv
